/* hw/rtl/bmp_row_pixel_replication_upscaler_core_macros.svh */
// Assertion macros used by the upscaler top level.
`ifndef BMP_ROW_PIXEL_REPLICATION_UPSCALER_CORE_MACROS_SVH
`define BMP_ROW_PIXEL_REPLICATION_UPSCALER_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define BMPUP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BMPUP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/bmpup_pkg.sv */
// Types and constants of the BMP row upscaler.
`default_nettype none

package bmpup_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int WIDTH_REG_W = 11;
   localparam int SCALE_REG_W = 7;
   localparam int COLUMN_W    = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 2'd1;

   typedef struct packed {
      logic                command;
      logic [COLUMN_W-1:0] column;
      logic [7:0]          blue_in;
      logic [7:0]          green_in;
      logic [7:0]          red_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       is_padding;
      logic       row_end;
      logic       repeat_done;
   } rsp_type;

   // per-pull status from the sequencer
   typedef struct packed {
      logic is_padding;
      logic row_end;
      logic repeat_done;
      logic pix_valid;
   } step_type;

endpackage

`default_nettype wire

/* hw/rtl/bmpup_line_mem.sv */
// Line buffer: one write port, one read port with registered read data.
`default_nettype none

module bmpup_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [23:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [23:0]   rd_data
);

   logic [23:0] line_mem [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bmpup_seq.sv */
// Output sequencer: column, pixel repeat, padding and row repeat counters.
`default_nettype none

module bmpup_seq #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 pull,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       eff_width,
   input  wire logic [$clog2(MAX_SCALE+1)-1:0]       eff_scale,
   output logic      [$clog2(MAX_WIDTH+1)-1:0]       rd_index,
   output bmpup_pkg::step_type                       step
);

   localparam int WIDX_W = $clog2(MAX_WIDTH+1);
   localparam int SW     = $clog2(MAX_SCALE+1);

   logic [WIDX_W-1:0] idx_ff, idx_in;
   logic [SW-1:0]     rep_ff, rep_in;
   logic [SW-1:0]     row_ff, row_in;
   logic [1:0]        pad_ff, pad_in;
   logic              in_pad_ff, in_pad_in;

   logic [1:0]        w2, s2, pad_bytes;
   logic [SW:0]       rep_sum, row_sum;
   logic [WIDX_W:0]   idx_sum;
   logic [2:0]        pad_sum;
   logic              pix_last, width_end, end_row, done;

   // bytes per row = 3*w*s, so the pad to a 4-byte multiple is w*s mod 4
   always_comb begin
      w2        = 2'(eff_width);
      s2        = 2'(eff_scale);
      pad_bytes = 2'(w2 * s2);
   end

   always_comb begin
      rep_sum   = {1'b0, rep_ff} + 1'b1;
      row_sum   = {1'b0, row_ff} + 1'b1;
      idx_sum   = {1'b0, idx_ff} + 1'b1;
      pad_sum   = {1'b0, pad_ff} + 1'b1;
      pix_last  = rep_sum >= {1'b0, eff_scale};
      width_end = pix_last && (idx_sum >= {1'b0, eff_width});
      if (in_pad_ff) begin
         end_row = pad_sum >= {1'b0, pad_bytes};
      end else begin
         end_row = width_end && (pad_bytes == 2'd0);
      end
      done = end_row && (row_sum >= {1'b0, eff_scale});

      idx_in    = idx_ff;
      rep_in    = rep_ff;
      row_in    = row_ff;
      pad_in    = pad_ff;
      in_pad_in = in_pad_ff;
      if (pull) begin
         if (end_row) begin
            in_pad_in = 1'b0;
            idx_in    = '0;
            rep_in    = '0;
            pad_in    = '0;
            row_in    = done ? '0 : SW'(row_sum);
         end else if (!in_pad_ff) begin
            rep_in = pix_last ? '0 : SW'(rep_sum);
            if (pix_last) begin
               idx_in = WIDX_W'(idx_sum);
            end
            if (width_end) begin
               in_pad_in = 1'b1;
               pad_in    = '0;
            end
         end else begin
            pad_in = 2'(pad_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rep_ff    <= '0;
         row_ff    <= '0;
         pad_ff    <= '0;
         in_pad_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rep_ff    <= rep_in;
         row_ff    <= row_in;
         pad_ff    <= pad_in;
         in_pad_ff <= in_pad_in;
      end
   end

   assign rd_index         = idx_ff;
   assign step.is_padding  = in_pad_ff;
   assign step.row_end     = end_row;
   assign step.repeat_done = done;
   assign step.pix_valid   = !in_pad_ff && (32'(idx_ff) < MAX_WIDTH);

endmodule

`default_nettype wire

/* hw/rtl/bmp_row_pixel_replication_upscaler_core.sv */
// Top level of the BMP row nearest-neighbor upscaler.
// Pipeline: a pull item's result is registered by the line buffer read,
//   then by the output register.
// Throughput: 1 item per cycle, loads and pulls alike, unless rsp_ready stalls;
//   set by the single line buffer port pair (write per load, read per pull).
// Reset: synchronous; clears all counters and sets width and scale to 1.
//   The line buffer is not cleared; reading a never-loaded column is undefined.
`default_nettype none

`include "bmp_row_pixel_replication_upscaler_core_macros.svh"

module bmp_row_pixel_replication_upscaler_core #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_SCALE = 100
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire bmpup_pkg::req_type                     req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output bmpup_pkg::rsp_type                          rsp_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [bmpup_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [bmpup_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int WIDX_W = $clog2(MAX_WIDTH+1);
   localparam int SW     = $clog2(MAX_SCALE+1);
   localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Effective (clamped) config, stored at write time.
   logic [WIDX_W-1:0] width_ff, width_in;
   logic [SW-1:0]     scale_ff, scale_in;
   logic [bmpup_pkg::WIDTH_REG_W-1:0] csr_width;
   logic [bmpup_pkg::SCALE_REG_W-1:0] csr_scale;

   // Pipeline: stage 1 holds the line buffer read, stage 2 is the output register.
   logic                s1_valid_ff, s1_valid_in;
   bmpup_pkg::step_type s1_step_ff;
   logic                out_valid_ff, out_valid_in;
   bmpup_pkg::rsp_type  out_ff, out_in;

   logic                req_fire, is_load, is_pull, load_en, s1_move, out_free;
   logic [WIDX_W-1:0]   rd_index;
   logic [23:0]         rd_pixel;
   bmpup_pkg::step_type step;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign csr_width = csr_data[bmpup_pkg::WIDTH_REG_W-1:0];
   assign csr_scale = csr_data[bmpup_pkg::SCALE_REG_W-1:0];

   always_comb begin
      width_in = width_ff;
      scale_in = scale_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bmpup_pkg::CSR_SOURCE_WIDTH: begin
               // zero acts as one, above the buffer depth acts as the depth
               if (csr_width == '0) begin
                  width_in = WIDX_W'(1);
               end else if (32'(csr_width) > MAX_WIDTH) begin
                  width_in = WIDX_W'(MAX_WIDTH);
               end else begin
                  width_in = WIDX_W'(csr_width);
               end
            end
            bmpup_pkg::CSR_SCALE_FACTOR: begin
               if (csr_scale == '0) begin
                  scale_in = SW'(1);
               end else if (32'(csr_scale) > MAX_SCALE) begin
                  scale_in = SW'(MAX_SCALE);
               end else begin
                  scale_in = SW'(csr_scale);
               end
            end
            default: begin
               width_in = width_ff;
               scale_in = scale_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDX_W'(1);
         scale_ff <= SW'(1);
      end else begin
         width_ff <= width_in;
         scale_ff <= scale_in;
      end
   end

   // ---------------- input handshake ----------------
   // Stage 1 drains into the output register whenever that register is free
   // or being emptied; a new item is taken whenever stage 1 can make room.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign is_load   = req_fire && (req_data.command == bmpup_pkg::CMD_LOAD);
   assign is_pull   = req_fire && (req_data.command == bmpup_pkg::CMD_PULL);

   // loads past the buffer depth are dropped
   assign load_en   = is_load && (32'(req_data.column) < MAX_WIDTH);

   // ---------------- line buffer ----------------
   // Reads and writes happen at the accept edge of their item, so item
   // order already orders buffer accesses; no forwarding is needed.
   bmpup_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_data.column)),
      .wr_data ({req_data.red_in, req_data.green_in, req_data.blue_in}),
      .rd_en   (is_pull),
      .rd_addr (AW'(rd_index)),
      .rd_data (rd_pixel)
   );

   // ---------------- counters ----------------
   bmpup_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .pull      (is_pull),
      .eff_width (width_ff),
      .eff_scale (scale_ff),
      .rd_index  (rd_index),
      .step      (step)
   );

   // ---------------- stage 1 ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (is_pull) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_pull) begin
         s1_step_ff <= step;
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (s1_move) begin
         out_valid_in = 1'b1;
         // padding and out-of-buffer columns read as zero
         if (s1_step_ff.pix_valid) begin
            out_in.blue_out  = rd_pixel[7:0];
            out_in.green_out = rd_pixel[15:8];
            out_in.red_out   = rd_pixel[23:16];
         end else begin
            out_in.blue_out  = '0;
            out_in.green_out = '0;
            out_in.red_out   = '0;
         end
         out_in.is_padding  = s1_step_ff.is_padding;
         out_in.row_end     = s1_step_ff.row_end;
         out_in.repeat_done = s1_step_ff.repeat_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // ---------------- checks ----------------
   `BMPUP_ASSERT(a_pad_zero, rsp_valid && rsp_data.is_padding |-> (rsp_data.blue_out == 8'd0) && (rsp_data.green_out == 8'd0) && (rsp_data.red_out == 8'd0), "padding item carries nonzero pixel bytes")
   `BMPUP_ASSERT(a_done_is_row_end, rsp_valid && rsp_data.repeat_done |-> rsp_data.row_end, "repeat_done without row_end")
   `BMPUP_ASSERT(a_pull_fills_s1, is_pull |=> s1_valid_ff, "accepted pull did not reach stage 1")
   `BMPUP_ASSERT(a_stall_blocks_input, s1_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready, "input taken while pipeline is full")
   `BMPUP_ASSERT(a_cfg_nonzero, (width_ff != '0) && (scale_ff != '0), "effective width or scale is zero")
   `BMPUP_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid right after reset")

endmodule

`default_nettype wire
